// ===== rtl/srtx_pkg.sv =====
package srtx_pkg;

  localparam int RX_DEPTH       = 128;
  localparam int TX_DEPTH       = 512;
  localparam int MAX_READ_BURST = 16;

  // pointer and count widths; a count must also hold the full depth
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int BURST_W = $clog2(MAX_READ_BURST + 1);
  localparam int LIM_W   = (BURST_W > 5) ? BURST_W : 5;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    OP_RX_BYTE  = 3'd0,
    OP_READ     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_TX_READY = 3'd3,
    OP_RX_RESET = 3'd4,
    OP_TX_RESET = 3'd5
  } op_t;

endpackage

// ===== rtl/srtx_ram.sv =====
module srtx_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/serial_rx_tx_ring_buffers.sv =====
// Buffered serial port core: a receive ring, a transmit ring and sticky status.
// Input requests arrive on in_* (opcode in in_tuser); each request produces one
// or more results on out_*, with out_tlast on the final result of a request.
// Byte received, host write, receive reset, transmit reset and unused opcodes
// give their single result from the output register loaded at acceptance, and
// in_tready stays high back to back while the result register drains, so these
// run one per cycle while out_tready is high. Transmitter ready with a byte
// queued does one transmit memory read, then gives the result. A host read
// burst, after its accept, does a receive memory read and then a result for
// each returned byte, up to 16 bytes; in_tready is low for the whole burst.
// An empty burst gives one result without data, loaded at acceptance.
// Reset (rst_n low, synchronous) empties both rings, clears the receive sticky
// bits and sets tx_empty; memory contents are not cleared.
// When out_tready is low the result is held in the output register, the
// sequencer waits and no new request is taken.
// out_tdata carries the result status after the action it reports.
module serial_rx_tx_ring_buffers (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // data_in[7:0], line_overrun[8], line_frame_error[9], line_parity_error[10],
  // read_limit[15:11]
  input  logic [srtx_pkg::IN_DATA_W-1:0] in_tdata,
  // opcode[2:0]
  input  logic [srtx_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // data_out[7:0], accepted[8], rx_fill[16:9], tx_fill[26:17], rx_overflow[27],
  // data_overrun[28], frame_error[29], parity_error[30], tx_empty[31]
  output logic [srtx_pkg::OUT_DATA_W-1:0] out_tdata,
  // data_valid[0]
  output logic                           out_tuser,
  output logic                           out_tlast
);

  import srtx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RXRD,
    S_RXOUT,
    S_TXOUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [RX_AW-1:0]     rx_wp_r, rx_wp_nxt;
  logic [RX_CW-1:0]     rx_count_r, rx_count_nxt;
  logic [TX_AW-1:0]     tx_rp_r, tx_rp_nxt;
  logic [TX_CW-1:0]     tx_count_r, tx_count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 ovr_r, ovr_nxt;
  logic                 frm_r, frm_nxt;
  logic                 par_r, par_nxt;
  logic                 txe_r, txe_nxt;
  logic [BURST_W-1:0]   burst_r, burst_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_user_r;
  logic                 out_last_r;

  logic                 slot_free;
  logic                 in_acc;
  op_t                  op;
  logic [7:0]           din;
  logic [LIM_W-1:0]     limit;
  logic [BURST_W-1:0]   limit_sat;

  logic                 res_load;
  logic [7:0]           res_byte;
  logic                 res_valid;
  logic                 res_last;
  logic                 res_acc;

  logic                 rx_we, rx_re;
  logic [RX_AW-1:0]     rx_raddr;
  logic [7:0]           rx_rdata;
  logic                 tx_we, tx_re;
  logic [TX_AW-1:0]     tx_waddr;
  logic [7:0]           tx_rdata;

  logic [RX_CW:0]       rx_wp_ext;
  logic [RX_CW:0]       rx_idx;
  logic [RX_CW-1:0]     rx_wp_inc;
  logic [TX_CW:0]       tx_idx;
  logic [TX_CW-1:0]     tx_rp_inc;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign din       = in_tdata[7:0];
  assign limit     = LIM_W'(in_tdata[15:11]);
  assign limit_sat = (limit > LIM_W'(MAX_READ_BURST)) ? BURST_W'(MAX_READ_BURST)
                                                        : BURST_W'(limit);

  // oldest receive entry: write pointer minus fill, modulo depth
  assign rx_wp_ext = (RX_CW + 1)'(rx_wp_r);
  assign rx_idx    = (rx_wp_ext >= (RX_CW + 1)'(rx_count_r))
                     ? rx_wp_ext - (RX_CW + 1)'(rx_count_r)
                     : rx_wp_ext + (RX_CW + 1)'(RX_DEPTH) - (RX_CW + 1)'(rx_count_r);
  assign rx_raddr  = rx_idx[RX_AW-1:0];
  assign rx_wp_inc = RX_CW'(rx_wp_r) + RX_CW'(1);

  // next free transmit entry: read pointer plus fill, modulo depth
  assign tx_idx    = ((TX_CW + 1)'(tx_rp_r) + (TX_CW + 1)'(tx_count_r) >=
                      (TX_CW + 1)'(TX_DEPTH))
                     ? (TX_CW + 1)'(tx_rp_r) + (TX_CW + 1)'(tx_count_r)
                       - (TX_CW + 1)'(TX_DEPTH)
                     : (TX_CW + 1)'(tx_rp_r) + (TX_CW + 1)'(tx_count_r);
  assign tx_waddr  = tx_idx[TX_AW-1:0];
  assign tx_rp_inc = TX_CW'(tx_rp_r) + TX_CW'(1);

  always_comb begin
    state_nxt    = state_r;
    rx_wp_nxt    = rx_wp_r;
    rx_count_nxt = rx_count_r;
    tx_rp_nxt    = tx_rp_r;
    tx_count_nxt = tx_count_r;
    ovf_nxt      = ovf_r;
    ovr_nxt      = ovr_r;
    frm_nxt      = frm_r;
    par_nxt      = par_r;
    txe_nxt      = txe_r;
    burst_nxt    = burst_r;
    res_load     = 1'b0;
    res_byte     = 8'd0;
    res_valid    = 1'b0;
    res_last     = 1'b1;
    res_acc      = 1'b0;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_load = 1'b1;
          case (op)
            OP_RX_BYTE: begin
              rx_we     = 1'b1;
              rx_wp_nxt = (rx_wp_inc >= RX_CW'(RX_DEPTH)) ? '0 : rx_wp_inc[RX_AW-1:0];
              if (rx_count_r == RX_CW'(RX_DEPTH)) begin
                ovf_nxt = 1'b1;
              end else begin
                rx_count_nxt = rx_count_r + RX_CW'(1);
              end
              ovr_nxt = ovr_r | in_tdata[8];
              frm_nxt = frm_r | in_tdata[9];
              par_nxt = par_r | in_tdata[10];
            end
            OP_READ: begin
              if (rx_count_r != '0 && limit_sat != '0) begin
                res_load  = 1'b0;
                burst_nxt = limit_sat;
                state_nxt = S_RXRD;
              end
            end
            OP_WRITE: begin
              if (tx_count_r != TX_CW'(TX_DEPTH)) begin
                tx_we        = 1'b1;
                tx_count_nxt = tx_count_r + TX_CW'(1);
                txe_nxt      = 1'b0;
                res_acc      = 1'b1;
              end
            end
            OP_TX_READY: begin
              if (tx_count_r != '0) begin
                res_load     = 1'b0;
                tx_re        = 1'b1;
                tx_rp_nxt    = (tx_rp_inc >= TX_CW'(TX_DEPTH)) ? '0
                                                                : tx_rp_inc[TX_AW-1:0];
                tx_count_nxt = tx_count_r - TX_CW'(1);
                state_nxt    = S_TXOUT;
              end else begin
                txe_nxt = 1'b1;
              end
            end
            OP_RX_RESET: begin
              rx_wp_nxt    = '0;
              rx_count_nxt = '0;
              ovf_nxt      = 1'b0;
              ovr_nxt      = 1'b0;
              frm_nxt      = 1'b0;
              par_nxt      = 1'b0;
            end
            OP_TX_RESET: begin
              tx_rp_nxt    = '0;
              tx_count_nxt = '0;
              txe_nxt      = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RXRD: begin
        rx_re        = 1'b1;
        rx_count_nxt = rx_count_r - RX_CW'(1);
        burst_nxt    = burst_r - BURST_W'(1);
        state_nxt    = S_RXOUT;
      end
      S_RXOUT: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res_byte  = rx_rdata;
          res_valid = 1'b1;
          res_last  = (burst_r == '0) || (rx_count_r == '0);
          state_nxt = res_last ? S_IDLE : S_RXRD;
        end
      end
      S_TXOUT: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res_byte  = tx_rdata;
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = res_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rx_wp_r     <= '0;
      rx_count_r  <= '0;
      tx_rp_r     <= '0;
      tx_count_r  <= '0;
      ovf_r       <= 1'b0;
      ovr_r       <= 1'b0;
      frm_r       <= 1'b0;
      par_r       <= 1'b0;
      txe_r       <= 1'b1;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rx_wp_r     <= rx_wp_nxt;
      rx_count_r  <= rx_count_nxt;
      tx_rp_r     <= tx_rp_nxt;
      tx_count_r  <= tx_count_nxt;
      ovf_r       <= ovf_nxt;
      ovr_r       <= ovr_nxt;
      frm_r       <= frm_nxt;
      par_r       <= par_nxt;
      txe_r       <= txe_nxt;
      burst_r     <= burst_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (res_load) begin
      out_data_r <= {txe_nxt, par_nxt, frm_nxt, ovr_nxt, ovf_nxt,
                     10'(tx_count_nxt), 8'(rx_count_nxt), res_acc, res_byte};
      out_user_r <= res_valid;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  srtx_ram #(
    .DEPTH (RX_DEPTH),
    .WIDTH (8)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wp_r),
    .wdata (din),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  srtx_ram #(
    .DEPTH (TX_DEPTH),
    .WIDTH (8)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (din),
    .re    (tx_re),
    .raddr (tx_rp_r),
    .rdata (tx_rdata)
  );

`ifndef SYNTHESIS
  a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_count_r <= RX_CW'(RX_DEPTH)) && (tx_count_r <= TX_CW'(TX_DEPTH)))
    else $error("ring fill count beyond depth");

  a_rx_byte_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_RX_BYTE) |=> (rx_count_r != '0))
    else $error("received byte left receive ring empty");

  a_write_clears_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[8]) |-> !out_data_r[31])
    else $error("accepted write reported with tx_empty set");

  a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RXRD) |-> (rx_count_r != '0) && !in_tready)
    else $error("burst read issued on empty receive ring");
`endif

endmodule

// ===== tb/sv/serial_rx_tx_ring_buffers_tb.sv =====
`timescale 1ns / 1ps

module serial_rx_tx_ring_buffers_tb;
  import srtx_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic              tx_empty;
    logic              parity_error;
    logic              frame_error;
    logic              data_overrun;
    logic              rx_overflow;
    logic [TX_CW-1:0]  tx_fill;
    logic [RX_CW-1:0]  rx_fill;
    logic              accepted;
    logic [7:0]        data_out;
  } status_word_t;

  typedef struct {
    status_word_t w;
    logic         data_valid;
    logic         last;
  } port_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  serial_rx_tx_ring_buffers DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of both rings and the status bits
  logic [7:0]       rx_ring [RX_DEPTH];
  logic [RX_AW-1:0] rx_wr = '0;
  logic [RX_CW-1:0] rx_level = '0;
  logic [7:0]       tx_ring [TX_DEPTH];
  logic [TX_AW-1:0] tx_rd = '0;
  logic [TX_CW-1:0] tx_level = '0;
  logic             st_rx_overflow = 1'b0;
  logic             st_overrun = 1'b0;
  logic             st_frame = 1'b0;
  logic             st_parity = 1'b0;
  logic             st_tx_empty = 1'b1;

  port_result_t expected_results[$];

  bit no_idle = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int results_checked = 0;
  int op_count [8];
  int rx_overwrites = 0;
  int tx_refusals = 0;
  int bytes_read = 0;
  int bytes_sent = 0;

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic int sender_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    return idle_length();
  endfunction

  function automatic port_result_t status_result(logic [7:0] b, bit valid, bit last_one,
                                                 bit acc);
    port_result_t r;
    r.w.data_out     = b;
    r.w.accepted     = acc;
    r.w.rx_fill      = rx_level;
    r.w.tx_fill      = tx_level;
    r.w.rx_overflow  = st_rx_overflow;
    r.w.data_overrun = st_overrun;
    r.w.frame_error  = st_frame;
    r.w.parity_error = st_parity;
    r.w.tx_empty     = st_tx_empty;
    r.data_valid     = valid;
    r.last           = last_one;
    return r;
  endfunction

  function automatic void predict_request(logic [2:0] op, logic [7:0] din, bit ovr, bit fe,
                                          bit pe, logic [4:0] lim);
    logic [RX_AW-1:0] rx_idx;
    logic [TX_AW-1:0] tx_idx;
    int burst;
    int n;
    case (op)
      OP_RX_BYTE: begin
        rx_ring[rx_wr] = din;
        rx_wr = rx_wr + 1'b1;
        if (rx_level == RX_DEPTH) begin
          st_rx_overflow = 1'b1;
          rx_overwrites++;
        end else begin
          rx_level = rx_level + 1'b1;
        end
        if (ovr) st_overrun = 1'b1;
        if (fe) st_frame = 1'b1;
        if (pe) st_parity = 1'b1;
        expected_results.push_back(status_result(8'h00, 0, 1, 0));
      end
      OP_READ: begin
        burst = (lim > MAX_READ_BURST) ? MAX_READ_BURST : lim;
        n = 0;
        while (rx_level != 0 && n < burst) begin
          rx_idx = RX_AW'(rx_wr - rx_level);
          rx_level = rx_level - 1'b1;
          expected_results.push_back(status_result(rx_ring[rx_idx], 1, 0, 0));
          n++;
        end
        bytes_read += n;
        if (n == 0) expected_results.push_back(status_result(8'h00, 0, 1, 0));
        else expected_results[expected_results.size() - 1].last = 1'b1;
      end
      OP_WRITE: begin
        if (tx_level < TX_DEPTH) begin
          tx_idx = TX_AW'(tx_rd + tx_level);
          tx_ring[tx_idx] = din;
          tx_level = tx_level + 1'b1;
          st_tx_empty = 1'b0;
          expected_results.push_back(status_result(8'h00, 0, 1, 1));
        end else begin
          tx_refusals++;
          expected_results.push_back(status_result(8'h00, 0, 1, 0));
        end
      end
      OP_TX_READY: begin
        if (tx_level != 0) begin
          tx_idx = tx_rd;
          tx_rd = tx_rd + 1'b1;
          tx_level = tx_level - 1'b1;
          bytes_sent++;
          expected_results.push_back(status_result(tx_ring[tx_idx], 1, 1, 0));
        end else begin
          st_tx_empty = 1'b1;
          expected_results.push_back(status_result(8'h00, 0, 1, 0));
        end
      end
      OP_RX_RESET: begin
        rx_wr = '0;
        rx_level = '0;
        st_rx_overflow = 1'b0;
        st_overrun = 1'b0;
        st_frame = 1'b0;
        st_parity = 1'b0;
        expected_results.push_back(status_result(8'h00, 0, 1, 0));
      end
      OP_TX_RESET: begin
        tx_rd = '0;
        tx_level = '0;
        st_tx_empty = 1'b1;
        expected_results.push_back(status_result(8'h00, 0, 1, 0));
      end
      default: expected_results.push_back(status_result(8'h00, 0, 1, 0));
    endcase
  endfunction

  // hold the request until in_tready, then predict at the accepting edge
  task automatic send_request(logic [2:0] op, logic [7:0] din, bit ovr, bit fe, bit pe,
                              logic [4:0] lim);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {lim, pe, fe, ovr, din};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(op, din, ovr, fe, pe, lim);
    op_count[op]++;
  endtask

  task automatic hold_off_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [4:0] any_limit();
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic random_request();
    int r;
    logic [2:0] op;
    logic [4:0] lim;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_RX_BYTE;
    else if (r < 50) op = OP_READ;
    else if (r < 70) op = OP_WRITE;
    else if (r < 90) op = OP_TX_READY;
    else if (r < 93) op = OP_RX_RESET;
    else if (r < 96) op = OP_TX_RESET;
    else if (r < 98) op = OP_SPARE_6;
    else op = OP_SPARE_7;
    r = $urandom_range(0, 99);
    if (r < 10) lim = 5'd0;
    else if (r < 25) lim = 5'($urandom_range(MAX_READ_BURST + 1, 31));
    else lim = 5'($urandom_range(1, MAX_READ_BURST));
    send_request(op, any_byte(), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                 $urandom_range(0, 9) == 0, lim);
  endtask

  task automatic test_directed_corners();
    send_request(OP_READ, any_byte(), 0, 0, 0, 5'd5);
    send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_SPARE_6, 8'h00, 0, 0, 0, 5'd0);
    send_request(OP_SPARE_7, 8'hFF, 1, 1, 1, 5'd31);
    send_request(OP_RX_BYTE, 8'h00, 0, 0, 0, 5'd0);
    send_request(OP_RX_BYTE, 8'hFF, 1, 0, 0, 5'd31);
    send_request(OP_RX_BYTE, 8'hA5, 0, 1, 0, any_limit());
    send_request(OP_RX_BYTE, 8'h5A, 0, 0, 1, any_limit());
    // zero limit returns no bytes even with bytes waiting
    send_request(OP_READ, any_byte(), 0, 0, 0, 5'd0);
    send_request(OP_READ, any_byte(), 1, 1, 1, 5'd31);
    send_request(OP_WRITE, 8'h00, 0, 0, 0, any_limit());
    send_request(OP_WRITE, 8'hFF, 1, 1, 1, any_limit());
    send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_RX_BYTE, 8'h3C, 1, 1, 1, any_limit());
    send_request(OP_RX_RESET, any_byte(), 1, 1, 1, any_limit());
    send_request(OP_READ, any_byte(), 0, 0, 0, 5'd16);
    send_request(OP_WRITE, 8'h81, 0, 0, 0, any_limit());
    send_request(OP_TX_RESET, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_RX_BYTE, 8'h7E, 0, 0, 0, any_limit());
    send_request(OP_READ, any_byte(), 0, 0, 0, 5'd1);
  endtask

  // overfill the receive ring so the write pointer wraps, then read it all back
  task automatic test_rx_overflow_wrap();
    int extra;
    hold_off_until_drained();
    send_request(OP_RX_RESET, any_byte(), 0, 0, 0, any_limit());
    extra = $urandom_range(2, 20);
    repeat (RX_DEPTH + extra)
      send_request(OP_RX_BYTE, any_byte(), $urandom_range(0, 19) == 0,
                   $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0, any_limit());
    while (rx_level != 0)
      send_request(OP_READ, any_byte(), 0, 0, 0, 5'($urandom_range(1, 31)));
    send_request(OP_READ, any_byte(), 0, 0, 0, 5'($urandom_range(1, 31)));
  endtask

  // fill the transmit ring, get refused, then drain past the read pointer wrap
  task automatic test_tx_full_wrap();
    hold_off_until_drained();
    send_request(OP_TX_RESET, any_byte(), 0, 0, 0, any_limit());
    repeat (TX_DEPTH) send_request(OP_WRITE, any_byte(), 0, 0, 0, any_limit());
    repeat (2) send_request(OP_WRITE, any_byte(), 1, 1, 1, any_limit());
    repeat (200) send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
    repeat (200) send_request(OP_WRITE, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_WRITE, any_byte(), 0, 0, 0, any_limit());
    while (tx_level != 0) send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
    send_request(OP_TX_READY, any_byte(), 0, 0, 0, any_limit());
  endtask

  task automatic test_random_traffic();
    repeat (180) random_request();
    hold_off_until_drained();
    repeat (180) random_request();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (60) random_request();
    no_idle = 1'b0;
  endtask

  // result-side stalls: mostly short, now and then long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 15) begin
      stall_left <= idle_length() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    port_result_t want;
    status_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got tdata %h tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_results.pop_front();
        check_field("data_out", 32'(want.w.data_out), 32'(got.data_out));
        check_field("data_valid", 32'(want.data_valid), 32'(out_tuser));
        check_field("last", 32'(want.last), 32'(out_tlast));
        check_field("accepted", 32'(want.w.accepted), 32'(got.accepted));
        check_field("rx_fill", 32'(want.w.rx_fill), 32'(got.rx_fill));
        check_field("tx_fill", 32'(want.w.tx_fill), 32'(got.tx_fill));
        check_field("rx_overflow", 32'(want.w.rx_overflow), 32'(got.rx_overflow));
        check_field("data_overrun", 32'(want.w.data_overrun), 32'(got.data_overrun));
        check_field("frame_error", 32'(want.w.frame_error), 32'(got.frame_error));
        check_field("parity_error", 32'(want.w.parity_error), 32'(got.parity_error));
        check_field("tx_empty", 32'(want.w.tx_empty), 32'(got.tx_empty));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
      $display("serial_rx_tx_ring_buffers_tb: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (op_count[i]) op_count[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_rx_overflow_wrap();
    test_tx_full_wrap();
    test_random_traffic();
    test_back_to_back();
    hold_off_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("requests: rx %0d, read %0d, write %0d, txrdy %0d, rxrst %0d, txrst %0d, spare %0d",
             op_count[OP_RX_BYTE], op_count[OP_READ], op_count[OP_WRITE],
             op_count[OP_TX_READY], op_count[OP_RX_RESET], op_count[OP_TX_RESET],
             op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
    $display("%0d results checked; %0d bytes read, %0d sent, %0d rx overwrites, %0d tx refusals",
             results_checked, bytes_read, bytes_sent, rx_overwrites, tx_refusals);
    if (mismatches == 0) begin
      $display("serial_rx_tx_ring_buffers_tb: done, clean");
    end else begin
      $display("serial_rx_tx_ring_buffers_tb: done, errors");
    end
    $finish;
  end

endmodule
